/* design/stbs_pkg.sv */
package stbs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int BOUND_W  = 11;
    localparam int POS_W    = 10;
    localparam int CNT_W    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic write_en;
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic done;
    } status_t;

endpackage

/* design/stbs_ctrl.sv */
module stbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                op,
    input  logic                out_stall,
    input  stbs_pkg::status_t   status,
    output stbs_pkg::cmd_t      cmd,
    output logic                in_stall,
    output logic                out_valid
);

    typedef enum logic {
        ST_IDLE,
        ST_PROBE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == stbs_pkg::OP_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                    end
                end
            end
            ST_PROBE:
            begin
                if (status.done)
                begin
                    if (out_free)
                    begin
                        cmd.finish     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/stbs_datapath.sv */
module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                clk,
    input  stbs_pkg::cmd_t                      cmd,
    output stbs_pkg::status_t                   status,
    input  logic [stbs_pkg::INDEX_W-1:0]        write_index,
    input  logic signed [stbs_pkg::WORD_W-1:0]  write_value,
    input  logic signed [stbs_pkg::WORD_W-1:0]  search_key,
    input  logic [stbs_pkg::INDEX_W-1:0]        low_bound,
    input  logic signed [stbs_pkg::BOUND_W-1:0] high_bound,
    output logic                                found,
    output logic [stbs_pkg::POS_W-1:0]          position,
    output logic [stbs_pkg::CNT_W-1:0]          comparisons
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW     = ((ADDR_W > stbs_pkg::BOUND_W) ? ADDR_W : stbs_pkg::BOUND_W) + 2;
    localparam int EXT_W  = (VALUE_WIDTH > stbs_pkg::WORD_W) ? VALUE_WIDTH : stbs_pkg::WORD_W;

    localparam logic signed [IW-1:0] DEPTH_M1 = IW'(TABLE_DEPTH - 1);
    localparam logic signed [IW-1:0] ONE      = IW'(1);
    localparam logic [IW-1:0]        DEPTH_U  = IW'(TABLE_DEPTH);

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

    logic [stbs_pkg::WORD_W-1:0] wv_u;
    logic [stbs_pkg::WORD_W-1:0] key_u;
    logic [EXT_W-1:0]            wv_ext;
    logic [EXT_W-1:0]            key_ext;
    logic [VALUE_WIDTH-1:0]      wval;
    logic [VALUE_WIDTH-1:0]      kval;
    logic [IW-1:0]               widx_ext;
    logic                        wr_ok;

    logic signed [IW-1:0] lo_in;
    logic signed [IW-1:0] hi_in;
    logic signed [IW-1:0] hi_c;
    logic signed [IW-1:0] mid0;
    logic signed [IW-1:0] mid_up;
    logic signed [IW-1:0] mid_dn;
    logic signed [IW-1:0] rd_addr;

    logic signed [IW-1:0]   lo_reg;
    logic signed [IW-1:0]   hi_reg;
    logic signed [IW-1:0]   mid_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic                   empty_reg;
    logic [stbs_pkg::CNT_W-1:0] cnt_reg;

    logic                       found_reg;
    logic [stbs_pkg::POS_W-1:0] position_reg;
    logic [stbs_pkg::CNT_W-1:0] comparisons_reg;

    logic hit;
    logic lt;

    assign wv_u     = write_value;
    assign key_u    = search_key;
    assign wv_ext   = EXT_W'(wv_u);
    assign key_ext  = EXT_W'(key_u);
    assign wval     = wv_ext[VALUE_WIDTH-1:0];
    assign kval     = key_ext[VALUE_WIDTH-1:0];
    assign widx_ext = IW'(write_index);
    assign wr_ok    = (widx_ext < DEPTH_U);

    assign lo_in = signed'(IW'(low_bound));
    assign hi_in = IW'(high_bound);
    assign hi_c  = (hi_in > DEPTH_M1) ? DEPTH_M1 : hi_in;
    assign mid0  = lo_in + ((hi_c - lo_in) >>> 1);

    assign hit    = (rdata_reg == key_reg);
    assign lt     = (signed'(rdata_reg) < signed'(key_reg));
    assign mid_up = mid_reg + ONE + ((hi_reg - mid_reg - ONE) >>> 1);
    assign mid_dn = lo_reg + ((mid_reg - ONE - lo_reg) >>> 1);

    assign status.empty = empty_reg;
    assign status.hit   = hit;
    assign status.done  = empty_reg || hit || (lt ? (mid_reg == hi_reg) : (mid_reg == lo_reg));

    always_comb
    begin
        if (cmd.start)
        begin
            rd_addr = mid0;
        end
        else if (cmd.step)
        begin
            rd_addr = lt ? mid_up : mid_dn;
        end
        else
        begin
            rd_addr = mid_reg;
        end
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.write_en && wr_ok)
        begin
            mem[widx_ext[ADDR_W-1:0]] <= wval;
        end
        rdata_reg <= mem[rd_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lo_reg    <= lo_in;
            hi_reg    <= hi_c;
            mid_reg   <= mid0;
            key_reg   <= kval;
            empty_reg <= (lo_in > hi_c);
            cnt_reg   <= stbs_pkg::CNT_W'(1);
        end
        else if (cmd.step)
        begin
            mid_reg <= rd_addr;
            if (lt)
            begin
                lo_reg <= mid_reg + ONE;
            end
            else
            begin
                hi_reg <= mid_reg - ONE;
            end
            if (cnt_reg != stbs_pkg::CNT_MAX)
            begin
                cnt_reg <= cnt_reg + stbs_pkg::CNT_W'(1);
            end
        end
        if (cmd.finish)
        begin
            found_reg       <= hit && !empty_reg;
            position_reg    <= (hit && !empty_reg) ? mid_reg[stbs_pkg::POS_W-1:0] : '0;
            comparisons_reg <= empty_reg ? '0 : cnt_reg;
        end
    end

    assign found       = found_reg;
    assign position    = position_reg;
    assign comparisons = comparisons_reg;

endmodule

/* design/sorted_table_binary_search_top.sv */
// Binary search over a table of signed values that load words fill one entry at a time;
// software keeps the table sorted ascending. A load word (op 0) gives no result and
// leaves the input side free; writes past the table depth are dropped. A search word
// (op 1) probes the midpoint of the clamped range once per cycle and holds the input
// side until it ends; it makes at most log2 of the depth plus one probes, 11 at 1024
// entries. The probe rate comes from the single registered read port of the table
// memory, which delivers one entry per cycle. The result waits in an output register;
// a search that ends while that register is still stalled holds until it frees.
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = stbs_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [stbs_pkg::INDEX_W-1:0]        write_index,
    input  logic signed [stbs_pkg::WORD_W-1:0]  write_value,
    input  logic signed [stbs_pkg::WORD_W-1:0]  search_key,
    input  logic [stbs_pkg::INDEX_W-1:0]        low_bound,
    input  logic signed [stbs_pkg::BOUND_W-1:0] high_bound,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [stbs_pkg::POS_W-1:0]          position,
    output logic [stbs_pkg::CNT_W-1:0]          comparisons
);

    stbs_pkg::cmd_t    cmd;
    stbs_pkg::status_t status;

    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .status      (status),
        .write_index (write_index),
        .write_value (write_value),
        .search_key  (search_key),
        .low_bound   (low_bound),
        .high_bound  (high_bound),
        .found       (found),
        .position    (position),
        .comparisons (comparisons)
    );

`ifndef SYNTH
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> in_stall)
        else $error("search finished outside a search");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> in_stall)
        else $error("search start did not hold the input side");

    a_found_probed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && status.hit && !status.empty) |=> (found && comparisons != '0))
        else $error("hit reported without a probe");

    a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (position == '0))
        else $error("miss with nonzero position");
`endif

endmodule

/* test/binary_search_checker.sv */
module binary_search_checker (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    input  logic                                         in_stall,
    input  logic                                         op,
    input  logic [stbs_pkg::INDEX_W-1:0]                 write_index,
    input  logic signed [stbs_pkg::WORD_W-1:0]           write_value,
    input  logic signed [stbs_pkg::WORD_W-1:0]           search_key,
    input  logic [stbs_pkg::INDEX_W-1:0]                 low_bound,
    input  logic signed [stbs_pkg::BOUND_W-1:0]          high_bound,
    input  logic                                         out_valid,
    input  logic                                         out_stall,
    input  logic                                         found,
    input  logic [stbs_pkg::POS_W-1:0]                   position,
    input  logic [stbs_pkg::CNT_W-1:0]                   comparisons,
    output int                                           mismatches,
    output int                                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH;

    typedef struct packed {
        logic                       found;
        logic [stbs_pkg::POS_W-1:0] position;
        logic [stbs_pkg::CNT_W-1:0] comparisons;
    } answer_t;

    logic signed [stbs_pkg::WORD_W-1:0] entries [0:DEPTH-1];
    answer_t                            answers_q [$];
    answer_t                            want;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic answer_t search_table(
        input logic signed [stbs_pkg::WORD_W-1:0]  key,
        input logic [stbs_pkg::INDEX_W-1:0]        lo_in,
        input logic signed [stbs_pkg::BOUND_W-1:0] hi_in
    );
        int      lo;
        int      hi;
        int      mid;
        int      probes;
        answer_t a;
        lo     = int'(lo_in);
        hi     = int'(hi_in);
        probes = 0;
        a      = '0;
        if (hi > DEPTH - 1)
            hi = DEPTH - 1;
        while (lo <= hi && !a.found)
        begin
            mid = lo + (hi - lo) / 2;
            probes++;
            if (entries[mid] == key)
            begin
                a.found    = 1'b1;
                a.position = mid[stbs_pkg::POS_W-1:0];
            end
            else if (entries[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        a.comparisons = (probes > 15) ? stbs_pkg::CNT_MAX : probes[stbs_pkg::CNT_W-1:0];
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answers_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answers_q.size() == 0)
                begin
                    $error("result word with no search outstanding");
                    mismatches++;
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        mismatches++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, position);
                        mismatches++;
                    end
                    if (comparisons !== want.comparisons)
                    begin
                        $error("comparisons: expected %0d, got %0d",
                               want.comparisons, comparisons);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (op == stbs_pkg::OP_SEARCH)
                    answers_q.push_back(search_table(search_key, low_bound, high_bound));
                else if (write_index < DEPTH)
                    entries[write_index] = write_value;
            end
            outstanding <= answers_q.size();
        end
    end

endmodule

/* test/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = stbs_pkg::DEFAULT_TABLE_DEPTH;
    localparam int PHASE_ITEMS = 350;
    localparam int IDLE_LIMIT  = 4000;
    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                                 clk         = 1'b0;
    logic                                 rst_n       = 1'b0;
    logic                                 in_valid    = 1'b0;
    logic                                 in_stall;
    logic                                 op          = stbs_pkg::OP_LOAD;
    logic [stbs_pkg::INDEX_W-1:0]         write_index = '0;
    logic signed [stbs_pkg::WORD_W-1:0]   write_value = '0;
    logic signed [stbs_pkg::WORD_W-1:0]   search_key  = '0;
    logic [stbs_pkg::INDEX_W-1:0]         low_bound   = '0;
    logic signed [stbs_pkg::BOUND_W-1:0]  high_bound  = '0;
    logic                                 out_valid;
    logic                                 out_stall   = 1'b0;
    logic                                 found;
    logic [stbs_pkg::POS_W-1:0]           position;
    logic [stbs_pkg::CNT_W-1:0]           comparisons;

    int mismatches;
    int outstanding;
    int send_pct  = 0;
    int stall_pct = 0;
    int items     = 0;
    int idle_cycles;

    logic signed [31:0] shadow [0:DEPTH-1];
    bit                 written [0:DEPTH-1];

    sorted_table_binary_search_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .write_index (write_index),
        .write_value (write_value),
        .search_key  (search_key),
        .low_bound   (low_bound),
        .high_bound  (high_bound),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position),
        .comparisons (comparisons)
    );

    binary_search_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .write_index (write_index),
        .write_value (write_value),
        .search_key  (search_key),
        .low_bound   (low_bound),
        .high_bound  (high_bound),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position),
        .comparisons (comparisons),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // ascending across the whole table: index in the top bits, free offset below
    function automatic logic signed [31:0] cell_value(input int idx, input logic [21:0] off);
        logic [9:0] i;
        i = idx[9:0];
        return {i, off} ^ 32'h8000_0000;
    endfunction

    task automatic send_word(
        input logic                        o,
        input logic [9:0]                  widx,
        input logic signed [31:0]          wval,
        input logic signed [31:0]          key,
        input logic [9:0]                  lo,
        input logic signed [10:0]          hi
    );
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        write_index <= widx;
        write_value <= wval;
        search_key  <= key;
        low_bound   <= lo;
        high_bound  <= hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items++;
        if (o == stbs_pkg::OP_LOAD)
        begin
            shadow[widx]  = wval;
            written[widx] = 1'b1;
        end
    endtask

    task automatic do_load(input int idx, input logic signed [31:0] val);
        send_word(stbs_pkg::OP_LOAD, idx[9:0], val, $urandom, 10'($urandom), 11'($urandom));
    endtask

    task automatic do_search(input logic signed [31:0] key, input int lo, input int hi);
        send_word(stbs_pkg::OP_SEARCH, 10'($urandom), $urandom, key, lo[9:0], hi[10:0]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic load_run();
        int                 base;
        int                 len;
        int                 i;
        logic signed [31:0] v;
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 24);
        base = $urandom_range(0, DEPTH - 1);
        for (i = base; i < base + len && i < DEPTH; i++)
        begin
            v = ($urandom_range(0, 99) < 3) ? $urandom : cell_value(i, 22'($urandom));
            do_load(i, v);
        end
    endtask

    task automatic random_search();
        int                 p;
        int                 s;
        int                 e;
        int                 lo;
        int                 hi;
        int                 k;
        int                 pick;
        logic signed [31:0] key;
        if ($urandom_range(0, 99) < 10)
        begin
            lo = $urandom_range(0, DEPTH - 1);
            hi = (lo == 0 || $urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, lo - 1);
            do_search($urandom, lo, hi);
        end
        else
        begin
            p = $urandom_range(0, DEPTH - 1);
            while (!written[p])
                p = (p + 1) % DEPTH;
            s = p;
            while (s > 0 && written[s - 1])
                s--;
            e = p;
            while (e < DEPTH - 1 && written[e + 1])
                e++;
            if ($urandom_range(0, 99) < 40)
            begin
                lo = s;
                hi = e;
            end
            else
            begin
                lo = $urandom_range(s, p);
                hi = $urandom_range(p, e);
            end
            k    = $urandom_range(lo, hi);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                key = shadow[k];
            else if (pick < 70)
                key = shadow[k] + ($urandom_range(0, 1) ? 1 : -1);
            else if (pick < 85)
                key = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
            else
                key = $urandom;
            do_search(key, lo, hi);
        end
    endtask

    initial
    begin
        int phase;
        int n;
        int i;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pct  = 37;
        stall_pct = 66;
        do_load(0, cell_value(0, 22'h000000));
        do_load(1, cell_value(1, 22'h3FFFFF));
        do_load(2, cell_value(2, 22'h000005));
        do_load(3, cell_value(3, 22'h2AAAAA));
        do_load(1021, cell_value(1021, 22'h000000));
        do_load(1022, cell_value(1022, 22'h155555));
        do_load(1023, cell_value(1023, 22'h3FFFFF));
        do_search(VALUE_MIN, 0, 3);
        do_search(shadow[3], 0, 3);
        do_search(shadow[2] + 1, 0, 3);
        do_search(VALUE_MAX, 1021, 1023);
        do_search(VALUE_MIN, 1023, 1023);
        do_search(VALUE_MAX, 0, 0);
        do_search(VALUE_MIN, 0, -1);
        do_search(VALUE_MAX, 1023, -1);
        do_search($urandom, 1023, 1022);
        do_search($urandom, 682, 341);
        // out of order entry, the probe sequence runs regardless
        do_load(3, VALUE_MIN);
        do_search(VALUE_MIN, 0, 3);
        do_search(shadow[2], 0, 3);
        do_load(3, cell_value(3, 22'h000007));
        do_search(shadow[3], 0, 3);
        drain();

        for (phase = 0; phase < 3; phase++)
        begin
            send_pct  = (phase == 0) ? 37 : (phase == 1) ? 66 : 0;
            stall_pct = (phase == 0) ? 66 : (phase == 1) ? 37 : 0;
            while (items < (phase + 1) * PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                    load_run();
                else
                begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        random_search();
                end
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("[sorted_table_binary_search_top] OK");
        else
            $display("[sorted_table_binary_search_top] ERROR");
        $finish;
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[sorted_table_binary_search_top] ERROR");
        $finish;
    end

endmodule

/* sorted_table_binary_search_top.f */
design/stbs_pkg.sv
design/stbs_ctrl.sv
design/stbs_datapath.sv
design/sorted_table_binary_search_top.sv
test/binary_search_checker.sv
test/testbench.sv
